// ----- rtl/ksjt_pkg.sv -----
package ksjt_pkg;

  // table geometry
  localparam int NODE_SLOTS = 1024;
  localparam int LEVELS     = 30;

  // fixed field widths
  localparam int NODE_W     = 11;
  localparam int COUNT_W    = 30;
  localparam int MODE_W     = 2;

  localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH      = LEVELS * NODE_SLOTS;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_NODE_COUNT = '0;
  localparam logic [NODE_W-1:0]     NODE_COUNT_RST = NODE_W'(1024);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_BUILD  = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_BUILD = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [NODE_W-1:0]  node_id;
    logic [NODE_W-1:0]  successor;
    logic [COUNT_W-1:0] jump_count;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] result_node;
  } out_item_t;

  // node ids 1..NODE_SLOTS have a row; 0 is none
  function automatic logic node_ok(input logic [NODE_W-1:0] node);
    return (node != '0) && (node <= NODE_W'(NODE_SLOTS));
  endfunction

  // flat address: level-major, row = node - 1
  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0]  lvl,
                                                 input logic [NODE_W-1:0] node);
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] base;
    row  = ADDR_W'(node - NODE_W'(1));
    base = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(NODE_SLOTS));
    return base + row;
  endfunction

endpackage

// ----- rtl/ksjt_cfg.sv -----
module ksjt_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ksjt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ksjt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ksjt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [ksjt_pkg::NODE_W-1:0]         node_count
);
  import ksjt_pkg::*;

  logic                  sel_node_count;
  logic                  wr_fire;
  logic [NODE_W-1:0]     node_count_r;
  logic [NODE_W-1:0]     node_count_nxt;

  assign pready         = 1'b1;
  assign sel_node_count = (paddr[CFG_ADDR_W-1:2] == REG_NODE_COUNT);
  assign wr_fire        = psel && penable && pwrite && pready;

  always_comb begin
    node_count_nxt = node_count_r;
    if (wr_fire && sel_node_count) begin
      node_count_nxt = pwdata[NODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_node_count) begin
      prdata = CFG_DATA_W'(node_count_r);
    end
  end

  assign node_count = node_count_r;

endmodule

// ----- rtl/kth_successor_jump_table.sv -----
// load: writes level 0 from idle; query: walks the levels top down, testing a count bit
// per level and reading a jump per set bit, with no walk for a zero count and an early
// stop once the walk reaches none; build: per node and level, reads the previous level's
// entry, then the midpoint's unless none, over min(node_count, 1024) nodes and 29 levels
// throughput: one item at a time, bound by the dependent table reads of the current item
// reset: control state and node_count (1024) reset synchronously; the table is not cleared
module kth_successor_jump_table (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ksjt_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output ksjt_pkg::out_item_t                 out_data,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ksjt_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ksjt_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ksjt_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import ksjt_pkg::*;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_BLD_RD0  = 7'b0000010,   // read own entry of previous level
    S_BLD_MID  = 7'b0000100,   // own entry back, read the midpoint entry or write none
    S_BLD_RD1  = 7'b0001000,   // midpoint entry back, write new level
    S_QRY_STEP = 7'b0010000,   // test count bit, issue a jump read
    S_QRY_DATA = 7'b0100000,   // jump read back
    S_FINISH   = 7'b1000000    // hand the result to the output register
  } state_t;

  state_t               state_r, state_nxt;

  logic [NODE_W-1:0]    node_count;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [NODE_W-1:0]    src_r, src_nxt;        // node being built
  logic [NODE_W-1:0]    last_r, last_nxt;      // last node of the build
  logic [NODE_W-1:0]    cur_r, cur_nxt;        // current query node
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   count_sh;
  out_item_t            res_r, res_nxt;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // jump table memory, one write and one read port
  logic [NODE_W-1:0]    mem [DEPTH];
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [NODE_W-1:0]    rd_data_r;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [NODE_W-1:0]    wr_data;

  logic                 in_fire;
  logic                 out_free;
  logic [NODE_W-1:0]    bld_n;
  logic                 bld_last_node;
  logic                 bld_last_lvl;

  // register block
  ksjt_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .node_count (node_count)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // build covers at most NODE_SLOTS nodes
  assign bld_n = (node_count > NODE_W'(NODE_SLOTS)) ? NODE_W'(NODE_SLOTS) : node_count;

  assign count_sh      = count_r >> lvl_r;
  assign bld_last_node = (src_r == last_r);
  assign bld_last_lvl  = (lvl_r == LVL_W'(LEVELS - 1));

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    src_nxt   = src_r;
    last_nxt  = last_r;
    cur_nxt   = cur_r;
    count_nxt = count_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.mode)
            MODE_LOAD: begin
              // level 0 write; successors out of range become none
              if (node_ok(in_data.node_id)) begin
                wr_en   = 1'b1;
                wr_addr = tbl_addr('0, in_data.node_id);
                wr_data = (in_data.successor > NODE_W'(NODE_SLOTS)) ? '0 : in_data.successor;
              end
            end
            MODE_BUILD: begin
              res_nxt.kind        = KIND_BUILD;
              res_nxt.result_node = '0;
              if ((bld_n == '0) || (LEVELS == 1)) begin
                state_nxt = S_FINISH;
              end else begin
                last_nxt  = bld_n;
                src_nxt   = NODE_W'(1);
                lvl_nxt   = LVL_W'(1);
                state_nxt = S_BLD_RD0;
              end
            end
            MODE_QUERY: begin
              res_nxt.kind = KIND_QUERY;
              if (in_data.jump_count == '0) begin
                // zero count passes the start node through untouched
                res_nxt.result_node = in_data.node_id;
                state_nxt           = S_FINISH;
              end else begin
                cur_nxt   = (in_data.node_id > NODE_W'(NODE_SLOTS)) ? '0 : in_data.node_id;
                count_nxt = in_data.jump_count;
                lvl_nxt   = LVL_W'(LEVELS - 1);
                state_nxt = S_QRY_STEP;
              end
            end
            default: begin
              // unused mode is dropped
            end
          endcase
        end
      end

      S_BLD_RD0: begin
        rd_en     = 1'b1;
        rd_addr   = tbl_addr(lvl_r - LVL_W'(1), src_r);
        state_nxt = S_BLD_MID;
      end

      S_BLD_MID: begin
        if (node_ok(rd_data_r)) begin
          rd_en     = 1'b1;
          rd_addr   = tbl_addr(lvl_r - LVL_W'(1), rd_data_r);
          state_nxt = S_BLD_RD1;
        end else begin
          // midpoint is none, so is the jump
          wr_en   = 1'b1;
          wr_addr = tbl_addr(lvl_r, src_r);
          wr_data = '0;
          if (bld_last_node) begin
            src_nxt = NODE_W'(1);
            lvl_nxt = lvl_r + LVL_W'(1);
          end else begin
            src_nxt = src_r + NODE_W'(1);
          end
          state_nxt = (bld_last_node && bld_last_lvl) ? S_FINISH : S_BLD_RD0;
        end
      end

      S_BLD_RD1: begin
        wr_en   = 1'b1;
        wr_addr = tbl_addr(lvl_r, src_r);
        wr_data = rd_data_r;
        if (bld_last_node) begin
          src_nxt = NODE_W'(1);
          lvl_nxt = lvl_r + LVL_W'(1);
        end else begin
          src_nxt = src_r + NODE_W'(1);
        end
        state_nxt = (bld_last_node && bld_last_lvl) ? S_FINISH : S_BLD_RD0;
      end

      S_QRY_STEP: begin
        if (!node_ok(cur_r)) begin
          // none is absorbing
          res_nxt.result_node = '0;
          state_nxt           = S_FINISH;
        end else if (count_sh[0]) begin
          rd_en     = 1'b1;
          rd_addr   = tbl_addr(lvl_r, cur_r);
          state_nxt = S_QRY_DATA;
        end else if (lvl_r == '0) begin
          res_nxt.result_node = cur_r;
          state_nxt           = S_FINISH;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end

      S_QRY_DATA: begin
        cur_nxt = rd_data_r;
        if (lvl_r == '0) begin
          res_nxt.result_node = rd_data_r;
          state_nxt           = S_FINISH;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_QRY_STEP;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: a waiting result does not block new input transfers
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if ((state_r == S_FINISH) && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    src_r      <= src_nxt;
    last_r     <= last_nxt;
    cur_r      <= cur_nxt;
    count_r    <= count_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // jump table: synchronous read into rd_data_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/kth_successor_jump_table_checker.sv -----
`timescale 1ns / 100ps

module kth_successor_jump_table_checker
  import ksjt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    pending
);

  // shadow of the jump table, row per node id, column per level
  bit [NODE_W-1:0] succ_tbl [1:NODE_SLOTS][0:LEVELS-1];
  logic [NODE_W-1:0] node_limit;
  out_item_t answer_q [$];
  int err_cnt;

  // one table step; none and ids past the table stay none
  function automatic logic [NODE_W-1:0] hop(input logic [NODE_W-1:0] node, input int lvl);
    if (node == '0 || node > NODE_SLOTS) return '0;
    return succ_tbl[node][lvl];
  endfunction

  function automatic void fill_levels();
    int n;
    n = (node_limit > NODE_SLOTS) ? NODE_SLOTS : int'(node_limit);
    for (int lv = 1; lv < LEVELS; lv++)
      for (int s = 1; s <= n; s++)
        succ_tbl[s][lv] = hop(succ_tbl[s][lv-1], lv - 1);
  endfunction

  function automatic logic [NODE_W-1:0] walk_jumps(input logic [NODE_W-1:0]  start,
                                                   input logic [COUNT_W-1:0] steps);
    logic [NODE_W-1:0] cur;
    cur = start;
    if (steps != '0) begin
      if (cur > NODE_SLOTS) cur = '0;
      for (int lv = LEVELS - 1; lv >= 0; lv--)
        if (cur != '0 && lv < COUNT_W && steps[lv]) cur = hop(cur, lv);
    end
    return cur;
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      node_limit = NODE_COUNT_RST;
      answer_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_NODE_COUNT) begin
        if (cfg_pwrite) begin
          node_limit = cfg_pwdata[NODE_W-1:0];
        end else if (cfg_prdata !== CFG_DATA_W'(node_limit)) begin
          $display("%0t: node_count read expected %0d actual %0d",
                   $time, node_limit, cfg_prdata);
          err_cnt++;
        end
      end
      // predict first so a same-edge result still finds its entry
      if (in_valid && in_ready) begin
        case (in_data.mode)
          MODE_LOAD: begin
            if (in_data.node_id != '0 && in_data.node_id <= NODE_SLOTS)
              succ_tbl[in_data.node_id][0] =
                (in_data.successor > NODE_SLOTS) ? '0 : in_data.successor;
          end
          MODE_BUILD: begin
            fill_levels();
            want.kind        = KIND_BUILD;
            want.result_node = '0;
            answer_q.push_back(want);
          end
          MODE_QUERY: begin
            want.kind        = KIND_QUERY;
            want.result_node = walk_jumps(in_data.node_id, in_data.jump_count);
            answer_q.push_back(want);
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d node %0d",
                   $time, out_data.kind, out_data.result_node);
          err_cnt++;
        end else begin
          want = answer_q.pop_front();
          if (out_data.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
            err_cnt++;
          end
          if (out_data.result_node !== want.result_node) begin
            $display("%0t: result_node expected %0d actual %0d",
                     $time, want.result_node, out_data.result_node);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending    <= answer_q.size();
  end

endmodule

// ----- tb/kth_successor_jump_table_test.sv -----
`timescale 1ns / 100ps

module kth_successor_jump_table_test;
  import ksjt_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int NODE_MAX      = (1 << NODE_W) - 1;
  localparam int COUNT_ALL     = (1 << COUNT_W) - 1;
  // a build of all table rows runs with no transfer at all
  localparam int STALL_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int PHASES        = 14;
  localparam int RANDOM_ITEMS  = 45;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int pending;
  int stall_cycles;
  // nodes 1..covered have every level written, and all their entries stay in 0..covered
  int covered;
  // no idling on either side while set
  bit steady;

  // node_count per phase: empty, one, two, full table, above the table, then small sizes
  int phase_cfg [PHASES] = '{0, 1, 2, 1024, 2047, 7, 33, 3, 60, 16, 64, 5, 40, 12};

  kth_successor_jump_table DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  kth_successor_jump_table_checker answer_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // result side back-pressure, about a quarter of the cycles unless steady
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 24);
  end

  // watchdog: any transfer on any port restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL kth_successor_jump_table");
      $finish;
    end
  end

  // one input transfer; random gaps before it, payload held until accepted
  task automatic offer_item(mode_t m, int unsigned node, int unsigned nxt, int unsigned cnt);
    in_item_t item;
    item.mode       = m;
    item.node_id    = NODE_W'(node);
    item.successor  = NODE_W'(nxt);
    item.jump_count = COUNT_W'(cnt);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every build and query has answered
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write node_count, then read it back in a back-to-back access
  task automatic program_node_count(int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_NODE_COUNT, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // node id that a load ignores and a nonzero query answers as none
  function automatic int unsigned stray_node();
    return $urandom_range(1) ? 0 : $urandom_range(NODE_MAX, NODE_SLOTS + 1);
  endfunction

  // successor for node j that keeps the table inside 0..eff, 0 being none
  // graph shapes: 0 random, 1 chain ending in none, 2 ring
  function automatic int unsigned pick_next(int j, int eff, int shape);
    int roll;
    roll = $urandom_range(99);
    if (eff == 0 || roll < 6) return 0;
    // too large, stored as none
    if (roll < 12) return $urandom_range(NODE_MAX, NODE_SLOTS + 1);
    case (shape)
      1:       return (j < eff) ? j + 1 : 0;
      2:       return (j < eff) ? j + 1 : 1;
      default: return $urandom_range(eff, 1);
    endcase
  endfunction

  // jump counts: full width, short walks, single levels, top bits, zero
  function automatic int unsigned pick_count(int eff);
    case ($urandom_range(4))
      0:       return $urandom & COUNT_ALL;
      1:       return $urandom_range(2 * eff + 4, 1);
      2:       return 1 << $urandom_range(COUNT_W - 1);
      3:       return $urandom_range(1) ? COUNT_ALL : (1 << (COUNT_W - 1)) | $urandom_range(7);
      default: return 0;
    endcase
  endfunction

  task automatic run_phase(int cfg_value);
    int eff;
    int shape;
    int roll;
    int nid;
    settle();
    program_node_count(cfg_value);
    eff   = (cfg_value > NODE_SLOTS) ? NODE_SLOTS : cfg_value;
    shape = $urandom_range(2);
    // every row the build walks must be loaded first; large tables only get the new rows
    for (int j = (eff > 256) ? covered + 1 : 1; j <= eff; j++)
      offer_item(MODE_LOAD, j, pick_next(j, eff, shape), $urandom & COUNT_ALL);
    // build ignores the other fields
    offer_item(MODE_BUILD, $urandom_range(NODE_MAX), $urandom_range(NODE_MAX),
               $urandom & COUNT_ALL);
    if (eff > covered) covered = eff;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        // zero count hands back any start node
        offer_item(MODE_QUERY, $urandom_range(NODE_MAX), $urandom_range(NODE_MAX), 0);
      end else if (roll < 9 || (roll < 55 && covered == 0)) begin
        offer_item(MODE_QUERY, stray_node(), $urandom_range(NODE_MAX), pick_count(eff));
      end else if (roll < 55) begin
        offer_item(MODE_QUERY, $urandom_range(covered, 1), $urandom_range(NODE_MAX),
                   pick_count(eff));
      end else if (roll < 80) begin
        // reload a row; upper levels keep their old values until the next build
        nid = $urandom_range(NODE_SLOTS, 1);
        offer_item(MODE_LOAD, nid, pick_next(nid, eff, shape), $urandom & COUNT_ALL);
      end else if (roll < 84 && eff <= 64) begin
        offer_item(MODE_BUILD, 0, 0, 0);
      end else if (roll < 92) begin
        offer_item(MODE_UNUSED, $urandom_range(NODE_MAX), $urandom_range(NODE_MAX),
                   $urandom & COUNT_ALL);
      end else begin
        offer_item(MODE_LOAD, stray_node(), $urandom_range(NODE_MAX), 0);
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    covered     = 0;
    steady      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: four nodes, 1 -> 2 -> 3 -> 4 -> 1
    program_node_count(4);
    offer_item(MODE_LOAD, 1, 2, 0);
    offer_item(MODE_LOAD, 2, 3, COUNT_ALL);
    offer_item(MODE_LOAD, 3, NODE_MAX, 0);       // successor past the table becomes none
    offer_item(MODE_LOAD, 3, 4, 0);
    offer_item(MODE_LOAD, 4, 1, 0);
    offer_item(MODE_LOAD, 0, 3, 0);              // bad node ids, ignored
    offer_item(MODE_LOAD, NODE_SLOTS + 1, 1, 0);
    offer_item(MODE_LOAD, NODE_MAX, 2, 0);
    offer_item(MODE_UNUSED, 1, 1, 1);            // unused mode, no result
    offer_item(MODE_BUILD, 0, 0, 0);
    covered = 4;
    offer_item(MODE_QUERY, 1, 0, 0);             // zero count
    offer_item(MODE_QUERY, NODE_MAX, 0, 0);      // zero count keeps a bad start
    offer_item(MODE_QUERY, NODE_MAX, 0, 1);      // bad start, nonzero count
    offer_item(MODE_QUERY, 0, 0, 5);             // none stays none
    offer_item(MODE_QUERY, 1, 0, 1);
    offer_item(MODE_QUERY, 1, 0, 3);
    offer_item(MODE_QUERY, 2, NODE_MAX, COUNT_ALL);
    offer_item(MODE_QUERY, 4, 0, 1 << (COUNT_W - 1));
    offer_item(MODE_LOAD, 4, 0, 0);              // level 0 only, upper levels go stale
    offer_item(MODE_QUERY, 4, 0, 1);
    offer_item(MODE_QUERY, 3, 0, 3);

    // random phases over node_count settings; two of them run with no idling
    for (int p = 0; p < PHASES; p++) begin
      steady = (p == 5 || p == 6);
      run_phase(phase_cfg[p]);
    end
    steady = 1'b0;

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS kth_successor_jump_table");
    else
      $display("FAIL kth_successor_jump_table");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ksjt_pkg.sv
rtl/ksjt_cfg.sv
rtl/kth_successor_jump_table.sv
tb/kth_successor_jump_table_checker.sv
tb/kth_successor_jump_table_test.sv
